// ===== rtl/pva_pkg.sv =====
package pva_pkg;

  // slot count default
  localparam int NUM_SLOTS_DEF = 32;

  // field widths
  localparam int CMD_W    = 2;
  localparam int PRIO_W   = 2;
  localparam int DIST_W   = 16;
  localparam int SLOT_W   = 5;
  localparam int CFG_W    = 12;
  localparam int CFG_IDX_W = 1;
  localparam int SCORE_W  = 19;

  // commands
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SETDIST = 2'd2;

  // priorities
  localparam logic [PRIO_W-1:0] PRIO_LOW    = 2'd0;
  localparam logic [PRIO_W-1:0] PRIO_NORMAL = 2'd1;
  localparam logic [PRIO_W-1:0] PRIO_HIGH   = 2'd2;

  // register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_PRIORITY_WEIGHT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEAL_MARGIN    = 1'd1;
  localparam logic [CFG_W-1:0] WEIGHT_RST = 12'd160;
  localparam logic [CFG_W-1:0] MARGIN_RST = 12'd80;

  typedef struct packed {
    logic              busy;
    logic [PRIO_W-1:0] prio;
    logic [DIST_W-1:0] distance;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  localparam entry_t ENTRY_RST = '{busy: 1'b0, prio: PRIO_NORMAL, distance: '0};

  // distance minus weight times priority, priority of three counts as high
  function automatic logic signed [SCORE_W-1:0] score_of(
    input logic [DIST_W-1:0] distance,
    input logic [PRIO_W-1:0] prio,
    input logic [CFG_W-1:0]  weight
  );
    logic [CFG_W:0] pw;
    begin
      case (prio)
        PRIO_LOW:    pw = '0;
        PRIO_NORMAL: pw = {1'b0, weight};
        default:     pw = {weight, 1'b0};
      endcase
      score_of = $signed(SCORE_W'(distance)) - $signed(SCORE_W'(pw));
    end
  endfunction

endpackage

// ===== rtl/pva_ram.sv =====
module pva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/priority_voice_allocator.sv =====
// Voice slot allocator with stealing. Each slot holds a busy flag, a priority
// and a listener distance in one synchronous slot memory; a valid bit per slot
// makes an entry that was never written read as free, normal priority, distance
// zero, so no clearing pass is needed after reset. An allocate word (tuser
// command 0) scans every slot through the single read port, one slot a cycle,
// tracking the lowest free slot, the first low-priority slot and the best
// steal candidate at once; it then grants the lowest free slot, or steals as
// follows: a low-priority request is denied, else the first low-priority slot
// is taken, else the first slot with the highest score (distance minus weight
// times priority) among those of priority at most the request's, if that
// score reaches the request's score plus steal_margin. Allocate is paced by
// the one slot read per cycle; release and set-distance are a
// read-modify-write of one entry. One result word is returned for every input
// word; a finished result waits in the output register while the next input
// word is taken. Configuration writes are taken any cycle but must only be
// issued while the block is idle.
module priority_voice_allocator
  import pva_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // input words
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [23:0]          s_axis_tdata,  // priority_req, distance, slot
  input  logic [CMD_W-1:0]     s_axis_tuser,  // command
  // result words
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,  // granted, granted_slot, stolen
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int AW = $clog2(NUM_SLOTS);
  localparam int CW = AW + 1;
  localparam int XW = (AW > SLOT_W) ? AW : SLOT_W;

  // controller states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_MOD    = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  logic [2:0] state;

  // configuration registers
  logic [CFG_W-1:0] priority_weight;
  logic [CFG_W-1:0] steal_margin;

  always_ff @(posedge clk) begin
    if (rst) begin
      priority_weight <= WEIGHT_RST;
      steal_margin    <= MARGIN_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_PRIORITY_WEIGHT: priority_weight <= cfg_wdata;
        REG_STEAL_MARGIN:    steal_margin    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input word unpacking
  logic [CMD_W-1:0]  in_command;
  logic [PRIO_W-1:0] in_prio;
  logic [DIST_W-1:0] in_dist;
  logic [SLOT_W-1:0] in_slot;
  logic [XW-1:0]     in_slot_x;
  logic              in_slot_ok;
  logic              in_fire;

  assign in_command = s_axis_tuser;
  assign in_prio    = s_axis_tdata[1:0];
  assign in_dist    = s_axis_tdata[17:2];
  assign in_slot    = s_axis_tdata[22:18];
  assign in_slot_x  = XW'(in_slot);
  assign in_slot_ok = 32'(in_slot) < 32'(NUM_SLOTS);

  assign s_axis_tready = (state == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // latched request
  logic [CMD_W-1:0]  req_cmd;
  logic [PRIO_W-1:0] req_prio;
  logic [DIST_W-1:0] req_dist;
  logic signed [SCORE_W-1:0] req_thresh;

  // slot memory and per-slot valid bits
  logic [AW-1:0]          ram_raddr;
  logic [ENTRY_W-1:0]     ram_rdata;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  entry_t                 ram_wentry;
  logic [NUM_SLOTS-1:0]   written;
  logic [AW-1:0]          rd_idx;
  logic                   rd_vld;
  entry_t                 rd_entry;

  pva_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wentry),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // never written entries read as the reset slot
  assign rd_entry = written[rd_idx] ? entry_t'(ram_rdata) : ENTRY_RST;

  // scan counter, runs 0..NUM_SLOTS
  logic [CW-1:0] cnt;
  logic          scan_issue;

  assign scan_issue = (state == ST_SCAN) && (cnt != CW'(NUM_SLOTS));
  assign ram_raddr  = (state == ST_IDLE) ? in_slot_x[AW-1:0] : cnt[AW-1:0];

  // scan results
  logic                      free_found, low_found, best_found;
  logic [AW-1:0]             free_idx, low_idx, best_idx;
  logic signed [SCORE_W-1:0] best_score;
  logic signed [SCORE_W-1:0] cur_score;

  assign cur_score = score_of(rd_entry.distance, rd_entry.prio, priority_weight);

  // allocation decision
  logic          grant;
  logic          steal;
  logic [AW-1:0] pick;

  always_comb begin
    grant = 1'b0;
    steal = 1'b0;
    pick  = free_idx;
    if (free_found) begin
      grant = 1'b1;
    end else if (req_prio == PRIO_LOW) begin
      grant = 1'b0;
    end else if (low_found) begin
      grant = 1'b1;
      steal = 1'b1;
      pick  = low_idx;
    end else if (best_found && (best_score >= req_thresh)) begin
      grant = 1'b1;
      steal = 1'b1;
      pick  = best_idx;
    end
  end

  // memory writes: granted slot or read-modify-write of one entry
  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = pick;
    ram_wentry = rd_entry;
    if (state == ST_DECIDE) begin
      ram_we     = grant;
      ram_wentry = '{busy: 1'b1, prio: req_prio, distance: req_dist};
    end else if (state == ST_MOD) begin
      ram_we    = 1'b1;
      ram_waddr = rd_idx;
      if (req_cmd == CMD_RELEASE) begin
        ram_wentry.busy = 1'b0;
      end else begin
        ram_wentry.distance = req_dist;
      end
    end
  end

  // result word being built
  logic              res_granted;
  logic [SLOT_W-1:0] res_slot;
  logic              res_stolen;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      written       <= '0;
      rd_vld        <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      rd_vld <= scan_issue;
      if (ram_we) begin
        written[ram_waddr] <= 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready && state != ST_DONE) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_command == CMD_ALLOC) begin
              state <= ST_SCAN;
            end else if ((in_command == CMD_RELEASE || in_command == CMD_SETDIST)
                         && in_slot_ok) begin
              state <= ST_MOD;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_SCAN: begin
          if (!scan_issue && !rd_vld) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: state <= ST_DONE;
        ST_MOD:    state <= ST_DONE;
        ST_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rd_idx     <= ram_raddr;
    req_thresh <= score_of(req_dist, req_prio, priority_weight)
                  + $signed(SCORE_W'(steal_margin));
    if (in_fire) begin
      req_cmd     <= in_command;
      req_prio    <= (in_prio == 2'd3) ? PRIO_HIGH : in_prio;
      req_dist    <= in_dist;
      cnt         <= '0;
      free_found  <= 1'b0;
      low_found   <= 1'b0;
      best_found  <= 1'b0;
      res_granted <= 1'b0;
      res_slot    <= '0;
      res_stolen  <= 1'b0;
    end
    if (scan_issue) begin
      cnt <= cnt + CW'(1);
    end
    if (rd_vld) begin
      if (!rd_entry.busy && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= rd_idx;
      end
      if (rd_entry.prio == PRIO_LOW && !low_found) begin
        low_found <= 1'b1;
        low_idx   <= rd_idx;
      end
      if (rd_entry.prio <= req_prio && (!best_found || cur_score > best_score)) begin
        best_found <= 1'b1;
        best_idx   <= rd_idx;
        best_score <= cur_score;
      end
    end
    if (state == ST_DECIDE && grant) begin
      res_granted <= 1'b1;
      res_slot    <= SLOT_W'(pick);
      res_stolen  <= steal;
    end
    if (state == ST_DONE && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= {1'b0, res_stolen, res_slot, res_granted};
    end
  end

  // checks
  a_stolen_needs_grant: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[6] |-> m_axis_tdata[0])
    else $error("stolen flagged without a grant");

  a_denied_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[6:1] == 6'd0)
    else $error("denied result carries slot or stolen bits");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> cnt <= CW'(NUM_SLOTS))
    else $error("scan counter ran past the slot count");

  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == ST_DECIDE || state == ST_MOD)
    else $error("slot memory written outside a write phase");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !s_axis_tready)
    else $error("new word taken before the previous one finished");

endmodule
